// ===== src/tvu_pkg.sv =====
// ----------------------------------------------------------------------------
// tvu_pkg
// Shared widths and defaults for the trilinear volume upsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tvu_pkg;

    localparam int SAMPLE_W       = 16;  // corner sample / result value
    localparam int OFFSET_W       = 3;   // y, z and x sub-offset fields
    localparam int MAX_RESULTS    = 8;   // results per item, upper bound
    localparam int FACTOR_DEFAULT = 8;

    localparam int S_TDATA_W = ((8 * SAMPLE_W + 2 * OFFSET_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_W + OFFSET_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/trilinear_volume_upsampler.sv =====
// ----------------------------------------------------------------------------
// trilinear_volume_upsampler
// Trilinear upsampling of one voxel cell per input item into up to eight
// x sub-positions; rounded half up blend of the eight corners.
// ----------------------------------------------------------------------------
// An accepted item passes the issue register and stages 1 to 7 before its first result shows on m_tvalid.
// Throughput: one result per cycle while m_tready does not stall; an item yields min(FACTOR, 8)
//   results, or one at the last x column, stepped by the x-offset issue counter.
// Pipeline: issue register, y blend, z blend, x blend, bias, reciprocal
//   multiply, back multiply, correction / output register.
// Reset: aresetn (sync, active low) clears valid bits and the issue counter.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_volume_upsampler
    import tvu_pkg::*;
#(
    parameter int FACTOR = FACTOR_DEFAULT   // 2..16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, lowest bit up: corner_x0y0z0, corner_x1y0z0, corner_x0y1z0,
    // corner_x1y1z0, corner_x0y0z1, corner_x1y0z1, corner_x0y1z1,
    // corner_x1y1z1 (16 b each), y_offset (3 b), z_offset (3 b), zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,      // x_edge
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, lowest bit up: value (16 b signed), x_offset (3 b), zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast       // last
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int WW     = $clog2(FACTOR + 1);           // weight 0..FACTOR
    localparam int CNT    = (FACTOR < MAX_RESULTS) ? FACTOR : MAX_RESULTS;
    localparam int DIV    = FACTOR * FACTOR * FACTOR;     // blend divisor
    localparam int DW     = $clog2(DIV) + 1;
    localparam int HALF_D = DIV / 2;
    localparam int BIAS   = 32768 * DIV;                  // makes sum >= 0
    localparam int UW     = SAMPLE_W + $clog2(DIV);       // biased sum width
    localparam int MW     = SAMPLE_W + 1;                 // quotient estimate
    localparam int RECIP  = (2 ** UW) / DIV;              // floor(2^UW / D)
    localparam int Y1W    = SAMPLE_W + WW + 2;
    localparam int Z2W    = Y1W + WW + 2;
    localparam int X3W    = Z2W + WW + 2;
    localparam int PW     = UW + MW;
    localparam int QDW    = DW + MW;

    logic en;   // whole pipeline advances
    assign en = !m_tvalid || m_tready;

    // ------------------------------------------------------------------
    // Stage 0: issue register, holds one item and steps x offset k
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] corner_reg [8];
    logic [WW-1:0]              wy0_reg, wy1_reg, wz0_reg, wz1_reg;
    logic [OFFSET_W-1:0]        k_reg, kmax_reg;
    logic                       busy_reg;

    logic                       k_last;
    logic                       load;
    logic [OFFSET_W-1:0]        y_in, z_in;
    logic [WW-1:0]              y_clamp, z_clamp;

    assign k_last   = (k_reg == kmax_reg);
    assign s_tready = !busy_reg || (en && k_last);
    assign load     = s_tvalid && s_tready;

    assign y_in = s_tdata[8*SAMPLE_W +: OFFSET_W];
    assign z_in = s_tdata[8*SAMPLE_W+OFFSET_W +: OFFSET_W];

    // offsets at or beyond FACTOR saturate to FACTOR-1
    always_comb begin
        if (WW'(y_in) >= WW'(FACTOR)) begin
            y_clamp = WW'(FACTOR - 1);
        end else begin
            y_clamp = WW'(y_in);
        end
        if (WW'(z_in) >= WW'(FACTOR)) begin
            z_clamp = WW'(FACTOR - 1);
        end else begin
            z_clamp = WW'(z_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end else if (en && busy_reg) begin
            if (k_last) begin
                busy_reg <= 1'b0;
            end else begin
                k_reg <= k_reg + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 8; i++) begin
                corner_reg[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
            end
            wy1_reg  <= y_clamp;
            wy0_reg  <= WW'(FACTOR) - y_clamp;
            wz1_reg  <= z_clamp;
            wz0_reg  <= WW'(FACTOR) - z_clamp;
            kmax_reg <= s_tlast ? '0 : OFFSET_W'(CNT - 1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: y blend, yb[x + 2z]
    // ------------------------------------------------------------------
    logic signed [Y1W-1:0] yb_next [4];
    logic signed [Y1W-1:0] yb_reg  [4];
    logic [WW-1:0]         s1_wz0_reg, s1_wz1_reg;
    logic [OFFSET_W-1:0]   s1_k_reg;
    logic                  s1_last_reg, s1_valid_reg;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            yb_next[j] = Y1W'(corner_reg[(j % 2) + 4 * (j / 2)])
                           * $signed(Y1W'(wy0_reg))
                       + Y1W'(corner_reg[(j % 2) + 2 + 4 * (j / 2)])
                           * $signed(Y1W'(wy1_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                yb_reg[j] <= yb_next[j];
            end
            s1_wz0_reg  <= wz0_reg;
            s1_wz1_reg  <= wz1_reg;
            s1_k_reg    <= k_reg;
            s1_last_reg <= k_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: z blend, zb[x]
    // ------------------------------------------------------------------
    logic signed [Z2W-1:0] zb_next [2];
    logic signed [Z2W-1:0] zb_reg  [2];
    logic [OFFSET_W-1:0]   s2_k_reg;
    logic                  s2_last_reg, s2_valid_reg;

    always_comb begin
        for (int x = 0; x < 2; x++) begin
            zb_next[x] = Z2W'(yb_reg[x]) * $signed(Z2W'(s1_wz0_reg))
                       + Z2W'(yb_reg[x + 2]) * $signed(Z2W'(s1_wz1_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zb_reg[0]   <= zb_next[0];
            zb_reg[1]   <= zb_next[1];
            s2_k_reg    <= s1_k_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: x blend with wx0 = FACTOR-k, wx1 = k
    // ------------------------------------------------------------------
    logic [WW-1:0]         wx0, wx1;
    logic signed [X3W-1:0] sum_next, sum_reg;
    logic [OFFSET_W-1:0]   s3_k_reg;
    logic                  s3_last_reg, s3_valid_reg;

    assign wx1      = WW'(s2_k_reg);
    assign wx0      = WW'(FACTOR) - wx1;
    assign sum_next = X3W'(zb_reg[0]) * $signed(X3W'(wx0))
                    + X3W'(zb_reg[1]) * $signed(X3W'(wx1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg     <= sum_next;
            s3_k_reg    <= s2_k_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: u = sum + D/2 + 32768*D, in [0, 65536*D)
    // ------------------------------------------------------------------
    logic [X3W-1:0]      biased;
    logic [UW-1:0]       u4_reg;
    logic [OFFSET_W-1:0] s4_k_reg;
    logic                s4_last_reg, s4_valid_reg;

    assign biased = $unsigned(sum_reg) + X3W'(HALF_D + BIAS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u4_reg      <= biased[UW-1:0];
            s4_k_reg    <= s3_k_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: reciprocal multiply, estimate is q or q-1
    // ------------------------------------------------------------------
    logic [PW-1:0]       prod_reg;
    logic [UW-1:0]       u5_reg;
    logic [OFFSET_W-1:0] s5_k_reg;
    logic                s5_last_reg, s5_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= PW'(u4_reg) * PW'(RECIP);
            u5_reg      <= u4_reg;
            s5_k_reg    <= s4_k_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: back multiply qe * D
    // ------------------------------------------------------------------
    logic [MW-1:0]       qe;
    logic [MW-1:0]       qe_reg;
    logic [QDW-1:0]      qd_reg;
    logic [UW-1:0]       u6_reg;
    logic [OFFSET_W-1:0] s6_k_reg;
    logic                s6_last_reg, s6_valid_reg;

    assign qe = prod_reg[PW-1:UW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (en) begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qe_reg      <= qe;
            qd_reg      <= QDW'(qe) * QDW'(DIV);
            u6_reg      <= u5_reg;
            s6_k_reg    <= s5_k_reg;
            s6_last_reg <= s5_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: remainder correction, unbias, output register
    // ------------------------------------------------------------------
    logic [UW-1:0]       rem;
    logic [MW-1:0]       q;
    logic [SAMPLE_W-1:0] value_next;
    logic [SAMPLE_W-1:0] value_reg;
    logic [OFFSET_W-1:0] xoff_reg;
    logic                last_reg, valid_reg;

    assign rem = u6_reg - UW'(qd_reg);
    assign q   = (rem >= UW'(DIV)) ? qe_reg + MW'(1) : qe_reg;
    // q is value + 32768 in 0..65535: flip the sign bit
    assign value_next = {~q[SAMPLE_W-1], q[SAMPLE_W-2:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
            xoff_reg  <= s6_k_reg;
            last_reg  <= s6_last_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'({xoff_reg, value_reg});
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
